>>> design/hsw_pkg.sv
// ----------------------------------------------------------------------------
// hsw_pkg
// Shared types and constants for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package hsw_pkg;

    localparam int unsigned START_W    = 16;
    localparam int unsigned CHECK_W    = 8;
    localparam int unsigned TIMEOUT_W  = 12;
    localparam int unsigned INTERVAL_W = 21;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned BITIDX_W   = 6;
    localparam int unsigned FRAME_W    = 40;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [BITIDX_W-1:0]   FRAME_BITS = 6'd40;
    localparam logic [INTERVAL_W-1:0] SINCE_MAX  = {INTERVAL_W{1'b1}};

    localparam logic [START_W-1:0]    START_LOW_RST  = 16'd18000;
    localparam logic [CHECK_W-1:0]    RESP_LOW_RST   = 8'd40;
    localparam logic [CHECK_W-1:0]    RESP_HIGH_RST  = 8'd80;
    localparam logic [CHECK_W-1:0]    ONE_THRESH_RST = 8'd40;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST    = 12'd1000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST   = 21'd2000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_LOW  = 3'd0,
        REG_RESP_LOW   = 3'd1,
        REG_RESP_HIGH  = 3'd2,
        REG_ONE_THRESH = 3'd3,
        REG_TIMEOUT    = 3'd4,
        REG_INTERVAL   = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SOON  = 3'd1,
        ST_NO_LOW    = 3'd2,
        ST_NO_HIGH   = 3'd3,
        ST_LOW_TO    = 3'd4,
        ST_HIGH_TO   = 3'd5,
        ST_CHECKSUM  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START     = 3'd1,
        PH_RESP_LOW  = 3'd2,
        PH_RESP_HIGH = 3'd3,
        PH_TAIL      = 3'd4,
        PH_BIT_LOW   = 3'd5,
        PH_BIT_HIGH  = 3'd6
    } phase_t;

    typedef struct packed {
        logic [START_W-1:0]    start_low_ticks;
        logic [CHECK_W-1:0]    response_low_check_ticks;
        logic [CHECK_W-1:0]    response_high_check_ticks;
        logic [CHECK_W-1:0]    one_threshold_ticks;
        logic [TIMEOUT_W-1:0]  phase_timeout_ticks;
        logic [INTERVAL_W-1:0] min_interval_ticks;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [15:0]        humidity_tenths;
        status_t            status;
        logic               done_res;
        logic               drive_low;
    } result_t;

endpackage

>>> design/hsw_cfg.sv
// ----------------------------------------------------------------------------
// hsw_cfg
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module hsw_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [hsw_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [hsw_pkg::INTERVAL_W-1:0]    wr_data,
    output hsw_pkg::cfg_t                     cfg
);

    hsw_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_ticks           <= hsw_pkg::START_LOW_RST;
            cfg_reg.response_low_check_ticks  <= hsw_pkg::RESP_LOW_RST;
            cfg_reg.response_high_check_ticks <= hsw_pkg::RESP_HIGH_RST;
            cfg_reg.one_threshold_ticks       <= hsw_pkg::ONE_THRESH_RST;
            cfg_reg.phase_timeout_ticks       <= hsw_pkg::TIMEOUT_RST;
            cfg_reg.min_interval_ticks        <= hsw_pkg::INTERVAL_RST;
        end else if (wr_en) begin
            unique case (wr_index)
                hsw_pkg::REG_START_LOW:
                    cfg_reg.start_low_ticks <= wr_data[hsw_pkg::START_W-1:0];
                hsw_pkg::REG_RESP_LOW:
                    cfg_reg.response_low_check_ticks <= wr_data[hsw_pkg::CHECK_W-1:0];
                hsw_pkg::REG_RESP_HIGH:
                    cfg_reg.response_high_check_ticks <= wr_data[hsw_pkg::CHECK_W-1:0];
                hsw_pkg::REG_ONE_THRESH:
                    cfg_reg.one_threshold_ticks <= wr_data[hsw_pkg::CHECK_W-1:0];
                hsw_pkg::REG_TIMEOUT:
                    cfg_reg.phase_timeout_ticks <= wr_data[hsw_pkg::TIMEOUT_W-1:0];
                hsw_pkg::REG_INTERVAL:
                    cfg_reg.min_interval_ticks <= wr_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/hsw_core.sv
// ----------------------------------------------------------------------------
// hsw_core
// Protocol state and one-tick update: start pulse, response checks, bit
// timing, checksum and result formatting.
// ----------------------------------------------------------------------------
module hsw_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  logic              line_level,
    input  logic              read_request,
    input  hsw_pkg::cfg_t     cfg,
    output hsw_pkg::result_t  result
);

    hsw_pkg::phase_t                       phase_reg, phase_next;
    logic [hsw_pkg::COUNT_W-1:0]           count_reg, count_next;
    logic [hsw_pkg::BITIDX_W-1:0]          bit_idx_reg, bit_idx_next;
    logic [hsw_pkg::FRAME_W-1:0]           frame_reg, frame_next;
    logic [hsw_pkg::INTERVAL_W-1:0]        since_reg, since_next;

    logic                                  accepted;
    logic                                  fin;
    hsw_pkg::status_t                      fin_status;
    logic [hsw_pkg::COUNT_W-1:0]           count_inc;
    logic                                  timed_out;
    logic                                  one_bit;
    logic [9:0]                            sum;
    logic [14:0]                           mag;
    logic [15:0]                           mag_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= hsw_pkg::PH_IDLE;
            count_reg   <= '0;
            bit_idx_reg <= '0;
            frame_reg   <= '0;
            since_reg   <= hsw_pkg::SINCE_MAX;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            bit_idx_reg <= bit_idx_next;
            frame_reg   <= frame_next;
            since_reg   <= since_next;
        end
    end

    assign count_inc = count_reg + 16'd1;
    assign timed_out = count_reg > {4'd0, cfg.phase_timeout_ticks};
    assign one_bit   = count_reg > {8'd0, cfg.one_threshold_ticks};

    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        bit_idx_next = bit_idx_reg;
        frame_next   = frame_reg;
        accepted     = 1'b0;
        fin          = 1'b0;
        fin_status   = hsw_pkg::ST_OK;
        result       = '0;

        unique case (phase_reg)
            hsw_pkg::PH_IDLE: begin
                if (read_request) begin
                    if (since_reg < cfg.min_interval_ticks) begin
                        fin        = 1'b1;
                        fin_status = hsw_pkg::ST_TOO_SOON;
                    end else begin
                        accepted         = 1'b1;
                        frame_next       = '0;
                        bit_idx_next     = '0;
                        result.drive_low = 1'b1;
                        if (cfg.start_low_ticks <= 16'd1) begin
                            phase_next = hsw_pkg::PH_RESP_LOW;
                            count_next = '0;
                        end else begin
                            phase_next = hsw_pkg::PH_START;
                            count_next = 16'd1;
                        end
                    end
                end
            end
            hsw_pkg::PH_START: begin
                result.drive_low = 1'b1;
                count_next       = count_inc;
                if (count_inc >= cfg.start_low_ticks) begin
                    phase_next = hsw_pkg::PH_RESP_LOW;
                    count_next = '0;
                end
            end
            hsw_pkg::PH_RESP_LOW: begin
                count_next = count_inc;
                if (count_inc >= {8'd0, cfg.response_low_check_ticks}) begin
                    if (line_level) begin
                        fin        = 1'b1;
                        fin_status = hsw_pkg::ST_NO_LOW;
                    end else begin
                        phase_next = hsw_pkg::PH_RESP_HIGH;
                        count_next = '0;
                    end
                end
            end
            hsw_pkg::PH_RESP_HIGH: begin
                count_next = count_inc;
                if (count_inc >= {8'd0, cfg.response_high_check_ticks}) begin
                    if (!line_level) begin
                        fin        = 1'b1;
                        fin_status = hsw_pkg::ST_NO_HIGH;
                    end else begin
                        phase_next = hsw_pkg::PH_TAIL;
                        count_next = '0;
                    end
                end
            end
            hsw_pkg::PH_TAIL: begin
                if (line_level) begin
                    if (timed_out) begin
                        fin        = 1'b1;
                        fin_status = hsw_pkg::ST_HIGH_TO;
                    end else begin
                        count_next = count_inc;
                    end
                end else begin
                    phase_next = hsw_pkg::PH_BIT_LOW;
                    count_next = 16'd1;
                end
            end
            hsw_pkg::PH_BIT_LOW: begin
                if (!line_level) begin
                    if (timed_out) begin
                        fin        = 1'b1;
                        fin_status = hsw_pkg::ST_LOW_TO;
                    end else begin
                        count_next = count_inc;
                    end
                end else begin
                    phase_next = hsw_pkg::PH_BIT_HIGH;
                    count_next = 16'd1;
                end
            end
            hsw_pkg::PH_BIT_HIGH: begin
                if (line_level) begin
                    if (timed_out) begin
                        fin        = 1'b1;
                        fin_status = hsw_pkg::ST_HIGH_TO;
                    end else begin
                        count_next = count_inc;
                    end
                end else begin
                    frame_next   = {frame_reg[hsw_pkg::FRAME_W-2:0], one_bit};
                    bit_idx_next = bit_idx_reg + 6'd1;
                    if (bit_idx_next >= hsw_pkg::FRAME_BITS) begin
                        fin        = 1'b1;
                        fin_status = hsw_pkg::ST_OK;
                    end else begin
                        phase_next = hsw_pkg::PH_BIT_LOW;
                        count_next = 16'd1;
                    end
                end
            end
            default: begin
                phase_next = hsw_pkg::PH_IDLE;
                count_next = '0;
            end
        endcase

        sum = {2'd0, frame_next[39:32]} + {2'd0, frame_next[31:24]}
            + {2'd0, frame_next[23:16]} + {2'd0, frame_next[15:8]};
        if (fin_status == hsw_pkg::ST_OK && sum[7:0] != frame_next[7:0]) begin
            fin_status = hsw_pkg::ST_CHECKSUM;
        end

        mag     = {frame_next[22:16], frame_next[15:8]};
        mag_ext = {1'b0, mag};

        if (fin) begin
            phase_next      = hsw_pkg::PH_IDLE;
            count_next      = '0;
            result.done_res = 1'b1;
            result.status   = fin_status;
            if (fin_status == hsw_pkg::ST_OK) begin
                result.humidity_tenths    = frame_next[39:24];
                result.temperature_tenths = frame_next[23] ? -$signed(mag_ext)
                                                           : $signed(mag_ext);
            end
        end

        if (accepted) begin
            since_next = '0;
        end else if (since_reg != hsw_pkg::SINCE_MAX) begin
            since_next = since_reg + 21'd1;
        end else begin
            since_next = since_reg;
        end
    end

endmodule

>>> design/humidity_sensor_wire_reader.sv
// ----------------------------------------------------------------------------
// humidity_sensor_wire_reader
// Single-wire humidity and temperature sensor receiver, one sample tick per
// item.
// ----------------------------------------------------------------------------
// Each input item is one sample tick of the data line with a read request
// flag, and each tick yields exactly one result item carrying the line drive,
// a done flag, a status code and, on a good read, humidity and signed
// temperature in tenths. The block takes one item per cycle while the result
// side is not stalled: an input register feeds the one-tick state update,
// whose result lands in an output register, and a stall on the result side
// holds the input side only when both registers are full. Configuration
// writes are always accepted and should be made while the stream is idle.
module humidity_sensor_wire_reader (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // line_level, read_request
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,   // drive_low, done_res, status,
                                                       // humidity_tenths, temperature_tenths
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hsw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hsw_pkg::INTERVAL_W-1:0]  cfg_data
);

    logic              in_valid_reg;
    logic [1:0]        in_data_reg;
    logic              out_valid_reg;
    hsw_pkg::result_t  out_data_reg;
    hsw_pkg::result_t  result;
    hsw_pkg::cfg_t     cfg;
    logic              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    hsw_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hsw_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .line_level   (in_data_reg[0]),
        .read_request (in_data_reg[1]),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_data_reg};

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
// Each input item is one sample tick of the data line. Sensor replies are built
// tick by tick from the programmed timing: good frames, frames with a wrong
// checksum, missing response levels, phase timeouts and early requests. An
// internal model of the reader predicts the result item of every accepted tick,
// and the result stream is compared field by field. Timing settings change
// between phases while the stream is empty, and the sender and receiver idle
// at different rates from phase to phase.
module testbench;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 120;

    typedef enum {
        RD_GOOD, RD_BAD_SUM, RD_NO_LOW, RD_NO_HIGH, RD_TAIL_TO, RD_LOW_TO, RD_HIGH_TO
    } read_kind_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;  // line_level, read_request
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [39:0]                    m_tdata;         // drive_low, done_res, status,
                                                     // humidity_tenths, temperature_tenths
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [hsw_pkg::CFG_IDX_W-1:0]  cfg_index = hsw_pkg::REG_START_LOW;
    logic [hsw_pkg::INTERVAL_W-1:0] cfg_data  = '0;

    humidity_sensor_wire_reader i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    hsw_pkg::cfg_t sensor_cfg = '{hsw_pkg::START_LOW_RST, hsw_pkg::RESP_LOW_RST,
                                  hsw_pkg::RESP_HIGH_RST, hsw_pkg::ONE_THRESH_RST,
                                  hsw_pkg::TIMEOUT_RST, hsw_pkg::INTERVAL_RST};

    hsw_pkg::phase_t                rd_phase   = hsw_pkg::PH_IDLE;
    logic [hsw_pkg::COUNT_W-1:0]    cnt        = '0;
    logic [hsw_pkg::BITIDX_W-1:0]   bit_count  = '0;
    logic [hsw_pkg::FRAME_W-1:0]    frame_reg  = '0;
    logic [hsw_pkg::INTERVAL_W-1:0] since_read = hsw_pkg::SINCE_MAX;

    logic [7:0]        tick_queue[$];
    hsw_pkg::result_t  want_results[$];
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                mismatches     = 0;
    int                quiet_cycles   = 0;
    int                made           = 0;
    int                since_start    = 32'h4000_0000;

    task automatic end_read(inout hsw_pkg::result_t r, input hsw_pkg::status_t st);
        logic [14:0] mag;
        r.done_res = 1'b1;
        r.status   = st;
        if (st == hsw_pkg::ST_OK) begin
            mag = {frame_reg[22:16], frame_reg[15:8]};
            r.humidity_tenths    = frame_reg[39:24];
            r.temperature_tenths = frame_reg[23] ? 16'd0 - {1'b0, mag} : {1'b0, mag};
        end
        rd_phase = hsw_pkg::PH_IDLE;
        cnt      = '0;
    endtask

    task automatic count_or_fail(inout hsw_pkg::result_t r, input hsw_pkg::status_t st);
        if (cnt > sensor_cfg.phase_timeout_ticks) begin
            end_read(r, st);
        end else begin
            cnt++;
        end
    endtask

    task automatic sense_tick(input logic level, input logic req,
                              output hsw_pkg::result_t r);
        logic       take;
        logic       one_bit;
        logic [7:0] sum;
        r    = '0;
        take = 1'b0;
        case (rd_phase)
            hsw_pkg::PH_IDLE: begin
                if (req) begin
                    if (since_read < sensor_cfg.min_interval_ticks) begin
                        end_read(r, hsw_pkg::ST_TOO_SOON);
                    end else begin
                        take        = 1'b1;
                        frame_reg   = '0;
                        bit_count   = '0;
                        r.drive_low = 1'b1;
                        if (sensor_cfg.start_low_ticks <= 16'd1) begin
                            rd_phase = hsw_pkg::PH_RESP_LOW;
                            cnt      = '0;
                        end else begin
                            rd_phase = hsw_pkg::PH_START;
                            cnt      = 16'd1;
                        end
                    end
                end
            end
            hsw_pkg::PH_START: begin
                r.drive_low = 1'b1;
                cnt++;
                if (cnt >= sensor_cfg.start_low_ticks) begin
                    rd_phase = hsw_pkg::PH_RESP_LOW;
                    cnt      = '0;
                end
            end
            hsw_pkg::PH_RESP_LOW: begin
                cnt++;
                if (cnt >= {8'd0, sensor_cfg.response_low_check_ticks}) begin
                    if (level) begin
                        end_read(r, hsw_pkg::ST_NO_LOW);
                    end else begin
                        rd_phase = hsw_pkg::PH_RESP_HIGH;
                        cnt      = '0;
                    end
                end
            end
            hsw_pkg::PH_RESP_HIGH: begin
                cnt++;
                if (cnt >= {8'd0, sensor_cfg.response_high_check_ticks}) begin
                    if (!level) begin
                        end_read(r, hsw_pkg::ST_NO_HIGH);
                    end else begin
                        rd_phase = hsw_pkg::PH_TAIL;
                        cnt      = '0;
                    end
                end
            end
            hsw_pkg::PH_TAIL: begin
                if (level) begin
                    count_or_fail(r, hsw_pkg::ST_HIGH_TO);
                end else begin
                    rd_phase = hsw_pkg::PH_BIT_LOW;
                    cnt      = '0;
                    count_or_fail(r, hsw_pkg::ST_LOW_TO);
                end
            end
            hsw_pkg::PH_BIT_LOW: begin
                if (!level) begin
                    count_or_fail(r, hsw_pkg::ST_LOW_TO);
                end else begin
                    rd_phase = hsw_pkg::PH_BIT_HIGH;
                    cnt      = '0;
                    count_or_fail(r, hsw_pkg::ST_HIGH_TO);
                end
            end
            hsw_pkg::PH_BIT_HIGH: begin
                if (level) begin
                    count_or_fail(r, hsw_pkg::ST_HIGH_TO);
                end else begin
                    one_bit   = cnt > {8'd0, sensor_cfg.one_threshold_ticks};
                    frame_reg = {frame_reg[hsw_pkg::FRAME_W-2:0], one_bit};
                    bit_count++;
                    if (bit_count >= hsw_pkg::FRAME_BITS) begin
                        sum = frame_reg[39:32] + frame_reg[31:24] + frame_reg[23:16]
                            + frame_reg[15:8];
                        end_read(r, (sum == frame_reg[7:0]) ? hsw_pkg::ST_OK
                                                            : hsw_pkg::ST_CHECKSUM);
                    end else begin
                        rd_phase = hsw_pkg::PH_BIT_LOW;
                        cnt      = '0;
                        count_or_fail(r, hsw_pkg::ST_LOW_TO);
                    end
                end
            end
            default: begin
                rd_phase = hsw_pkg::PH_IDLE;
                cnt      = '0;
            end
        endcase
        if (take) begin
            since_read = '0;
        end else if (since_read != hsw_pkg::SINCE_MAX) begin
            since_read++;
        end
    endtask

    task automatic write_reg(input hsw_pkg::reg_idx_t idx, input int unsigned value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[hsw_pkg::INTERVAL_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            hsw_pkg::REG_START_LOW:
                sensor_cfg.start_low_ticks = value[hsw_pkg::START_W-1:0];
            hsw_pkg::REG_RESP_LOW:
                sensor_cfg.response_low_check_ticks = value[hsw_pkg::CHECK_W-1:0];
            hsw_pkg::REG_RESP_HIGH:
                sensor_cfg.response_high_check_ticks = value[hsw_pkg::CHECK_W-1:0];
            hsw_pkg::REG_ONE_THRESH:
                sensor_cfg.one_threshold_ticks = value[hsw_pkg::CHECK_W-1:0];
            hsw_pkg::REG_TIMEOUT:
                sensor_cfg.phase_timeout_ticks = value[hsw_pkg::TIMEOUT_W-1:0];
            hsw_pkg::REG_INTERVAL:
                sensor_cfg.min_interval_ticks = value[hsw_pkg::INTERVAL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(input int unsigned start_low, input int unsigned resp_low,
                              input int unsigned resp_high, input int unsigned one_thresh,
                              input int unsigned timeout, input int unsigned interval);
        write_reg(hsw_pkg::REG_START_LOW, start_low);
        write_reg(hsw_pkg::REG_RESP_LOW, resp_low);
        write_reg(hsw_pkg::REG_RESP_HIGH, resp_high);
        write_reg(hsw_pkg::REG_ONE_THRESH, one_thresh);
        write_reg(hsw_pkg::REG_TIMEOUT, timeout);
        write_reg(hsw_pkg::REG_INTERVAL, interval);
    endtask

    task automatic settle();
        while (tick_queue.size() != 0 || want_results.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    task automatic push_tick(input logic level, input logic req);
        tick_queue.push_back({6'b0, req, level});
        if (since_start < 32'h4000_0000) since_start++;
    endtask

    // requests inside a read are ignored by the reader
    task automatic push_busy(input logic level);
        push_tick(level, $urandom_range(0, 7) == 0);
        made++;
    endtask

    function automatic int run_len(int lo, int hi);
        if ($urandom_range(0, 15) == 0) return hi;
        return $urandom_range(lo, (hi > lo + 2) ? lo + 2 : hi);
    endfunction

    // pad so the next request is accepted, optionally after an early one
    task automatic pace_request(input logic early);
        if (since_start <= sensor_cfg.min_interval_ticks) begin
            if (early) push_tick(1'($urandom_range(0, 1)), 1'b1);
            while (since_start <= sensor_cfg.min_interval_ticks)
                push_tick(1'($urandom_range(0, 1)), 1'b0);
        end
    endtask

    task automatic sensor_read(input read_kind_t kind, input logic [31:0] payload);
        logic [39:0] frame;
        int          fail_at;
        int          flip;
        int          to_run;
        fail_at = $urandom_range(0, 39);
        flip    = $urandom_range(0, 7);
        to_run  = sensor_cfg.phase_timeout_ticks + 2;
        frame   = {payload, payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0]};
        if (kind == RD_BAD_SUM) frame[flip] = ~frame[flip];

        push_tick(1'($urandom_range(0, 1)), 1'b1);
        since_start = 1;
        made++;
        repeat (int'(sensor_cfg.start_low_ticks) - 1) push_busy(1'($urandom_range(0, 1)));

        repeat (int'(sensor_cfg.response_low_check_ticks) - 1)
            push_busy(1'($urandom_range(0, 1)));
        push_busy(kind == RD_NO_LOW);
        if (kind == RD_NO_LOW) return;
        repeat (int'(sensor_cfg.response_high_check_ticks) - 1)
            push_busy(1'($urandom_range(0, 1)));
        push_busy(kind != RD_NO_HIGH);
        if (kind == RD_NO_HIGH) return;

        if (kind == RD_TAIL_TO) begin
            repeat (to_run) push_busy(1'b1);
            return;
        end
        repeat (run_len(0, to_run - 1)) push_busy(1'b1);

        for (int i = 0; i < 40; i++) begin
            if (kind == RD_LOW_TO && i == fail_at) begin
                repeat (to_run) push_busy(1'b0);
                return;
            end
            repeat (run_len(1, to_run - 1)) push_busy(1'b0);
            if (kind == RD_HIGH_TO && i == fail_at) begin
                repeat (to_run) push_busy(1'b1);
                return;
            end
            if (frame[39-i]) begin
                repeat (run_len(sensor_cfg.one_threshold_ticks + 1, to_run - 1)) push_busy(1'b1);
            end else begin
                repeat (run_len(1, sensor_cfg.one_threshold_ticks)) push_busy(1'b1);
            end
        end
        push_busy(1'b0);
    endtask

    always @(posedge aclk) begin : drive_ticks
        hsw_pkg::result_t due;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                sense_tick(s_tdata[0], s_tdata[1], due);
                want_results.push_back(due);
            end
            if (!s_tvalid || s_tready) begin
                if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= tick_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] seen);
        if (want !== seen) begin
            if (mismatches < 40)
                $display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        hsw_pkg::result_t want;
        hsw_pkg::result_t seen;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = m_tdata[36:0];
                if (want_results.size() == 0) begin
                    if (mismatches < 40)
                        $display("%0t unexpected result item: expected none actual %0h",
                                 $time, m_tdata);
                    mismatches++;
                end else begin
                    want = want_results.pop_front();
                    check_field("drive_low", 16'(want.drive_low), 16'(seen.drive_low));
                    check_field("done_res", 16'(want.done_res), 16'(seen.done_res));
                    check_field("status", 16'(want.status), 16'(seen.status));
                    check_field("humidity_tenths", want.humidity_tenths, seen.humidity_tenths);
                    check_field("temperature_tenths", want.temperature_tenths,
                                seen.temperature_tenths);
                    check_field("padding", '0, 16'(m_tdata[39:37]));
                end
            end
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("humidity_sensor_wire_reader test failed");
            $finish;
        end
    end

    initial begin : run_test
        int         send_pct[4];
        int         recv_pct[4];
        int         thresh;
        int         pick;
        read_kind_t kind;
        send_pct = '{0, 49, 0, 37};
        recv_pct = '{0, 0, 49, 37};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // shortest timing, longest interval: first read allowed, next one early
        set_timing(1, 1, 1, 1, 1, hsw_pkg::SINCE_MAX);
        sensor_read(RD_GOOD, 32'hFFFF_FFFF);
        push_tick(1'b0, 1'b1);
        settle();

        write_reg(hsw_pkg::REG_INTERVAL, 0);
        sensor_read(RD_GOOD, 32'h0000_0000);
        sensor_read(RD_GOOD, 32'h0000_8000);
        sensor_read(RD_GOOD, 32'h1234_0001);
        sensor_read(RD_BAD_SUM, $urandom);
        sensor_read(RD_NO_LOW, $urandom);
        sensor_read(RD_NO_HIGH, $urandom);
        sensor_read(RD_TAIL_TO, $urandom);
        sensor_read(RD_LOW_TO, $urandom);
        sensor_read(RD_HIGH_TO, $urandom);
        settle();

        // widest check, threshold and timeout values
        set_timing(1, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 0);
        sensor_read(RD_NO_LOW, $urandom);

        for (int p = 0; p < 4; p++) begin
            settle();
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            thresh = $urandom_range(1, 3);
            set_timing($urandom_range(1, 10), $urandom_range(1, 5), $urandom_range(1, 5),
                       thresh, thresh + $urandom_range(0, 4), $urandom_range(0, 60));
            made = 0;
            while (made < PHASE_ITEMS) begin
                repeat ($urandom_range(0, 3)) push_tick(1'($urandom_range(0, 1)), 1'b0);
                pace_request($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 60) kind = RD_GOOD;
                else if (pick < 70) kind = RD_BAD_SUM;
                else kind = read_kind_t'($urandom_range(2, 6));
                sensor_read(kind, $urandom);
            end
        end

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("humidity_sensor_wire_reader test passed");
        end else begin
            $display("humidity_sensor_wire_reader test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/hsw_pkg.sv
design/hsw_cfg.sv
design/hsw_core.sv
design/humidity_sensor_wire_reader.sv
dv/testbench.sv
